// ===== rtl/core/prq_pkg.sv =====
// Shared types and codes for the priority ready queue.
package prq_pkg;

    localparam int unsigned TASK_W = 8;
    localparam int unsigned PRIO_W = 8;
    localparam int unsigned OCC_W  = 5;

    localparam logic [1:0] REQ_ENQUEUE = 2'd0;
    localparam logic [1:0] REQ_REMOVE  = 2'd1;
    localparam logic [1:0] REQ_PICK    = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
    localparam logic [1:0] STATUS_DUPLICATE = 2'd3;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [TASK_W-1:0] task_id;
        logic [PRIO_W-1:0] priority_req;
    } req_t;

    typedef struct packed {
        logic [TASK_W-1:0] picked_id;
        logic [PRIO_W-1:0] picked_priority;
        logic              is_idle;
        logic [1:0]        status;
        logic [OCC_W-1:0]  occupancy;
    } rsp_t;

endpackage

// ===== rtl/core/priority_ready_queue_rr.sv =====
// Priority ready queue with round-robin service among equal priorities.
//
// Command channel: a request beat (enqueue, remove or pick) is taken at a
// rising edge with start high and busy low. busy stays high until the
// request is finished. The response beat appears on rsp for exactly one
// cycle with done high; the receiver cannot stall it.
// Configuration: cfg_wr_en with cfg_wr_data sets the idle task id (reset 255).
// Entries live in one memory of QUEUE_DEPTH slots in service order, with one
// registered synchronous read port and one write port.
// A request scans all N queued entries, then shifts the affected entries
// one slot per cycle (up for enqueue, down for remove and pick), then writes
// the new slot (no write for remove) and returns the response. Duplicate,
// full, not-found and empty-pick requests are answered after the scan with
// no shift or write; an unused request code is answered from idle, unscanned.
// The next request can be taken in the cycle that done is high.
// Reset empties the queue; no clearing pass is needed since only slots
// below the count are ever read.
module priority_ready_queue_rr #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  prq_pkg::req_t              req,
    output logic                       done,
    output prq_pkg::rsp_t              rsp,
    input  logic                       cfg_wr_en,
    input  logic [prq_pkg::TASK_W-1:0] cfg_wr_data
);
    import prq_pkg::*;

    localparam int unsigned IW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [TASK_W-1:0] task_id;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_DECIDE = 5'b00100,
        S_MOVE   = 5'b01000,
        S_FINAL  = 5'b10000
    } state_t;

    entry_t mem [QUEUE_DEPTH];
    entry_t rd_data_reg;

    logic          mem_re;
    logic [IW-1:0] mem_raddr;
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    entry_t        mem_wdata;

    state_t            state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [TASK_W-1:0] idle_id_reg, idle_id_next;
    logic [1:0]        op_reg, op_next;
    logic [TASK_W-1:0] id_reg, id_next;
    logic [PRIO_W-1:0] key_reg, key_next;
    entry_t            head_reg, head_next;
    logic [CW-1:0]     iss_reg, iss_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [CW-1:0]     rd_pos_reg, rd_pos_next;
    logic              found_reg, found_next;
    logic [CW-1:0]     found_pos_reg, found_pos_next;
    logic              ins_found_reg, ins_found_next;
    logic [CW-1:0]     ins_pos_reg, ins_pos_next;
    logic [CW-1:0]     src_reg, src_next;
    logic [CW-1:0]     end_reg, end_next;
    logic              up_reg, up_next;
    logic              mv_iss_reg, mv_iss_next;
    logic              mv_vld_reg, mv_vld_next;
    logic [CW-1:0]     dst_reg, dst_next;
    logic [CW-1:0]     fin_pos_reg, fin_pos_next;
    logic              done_reg, done_next;
    rsp_t              rsp_reg, rsp_next;

    logic [PRIO_W-1:0] key_cur;
    logic [CW-1:0]     ins_pos_c;
    logic [CW-1:0]     cnt_new;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        idle_id_next   = cfg_wr_en ? cfg_wr_data : idle_id_reg;
        op_next        = op_reg;
        id_next        = id_reg;
        key_next       = key_reg;
        head_next      = head_reg;
        iss_next       = iss_reg;
        rd_vld_next    = 1'b0;
        rd_pos_next    = rd_pos_reg;
        found_next     = found_reg;
        found_pos_next = found_pos_reg;
        ins_found_next = ins_found_reg;
        ins_pos_next   = ins_pos_reg;
        src_next       = src_reg;
        end_next       = end_reg;
        up_next        = up_reg;
        mv_iss_next    = mv_iss_reg;
        mv_vld_next    = 1'b0;
        dst_next       = dst_reg;
        fin_pos_next   = fin_pos_reg;
        done_next      = 1'b0;
        rsp_next       = rsp_reg;
        mem_re         = 1'b0;
        mem_raddr      = '0;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = head_reg;
        key_cur        = key_reg;
        ins_pos_c      = ins_found_reg ? ins_pos_reg : cnt_reg;
        cnt_new        = cnt_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next        = req.req_type;
                    id_next        = req.task_id;
                    key_next       = req.priority_req;
                    iss_next       = '0;
                    found_next     = 1'b0;
                    ins_found_next = 1'b0;
                    if (req.req_type inside {REQ_ENQUEUE, REQ_REMOVE, REQ_PICK})
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        done_next          = 1'b1;
                        rsp_next           = '0;
                        rsp_next.occupancy = OCC_W'(cnt_reg);
                    end
                end
            end

            S_SCAN:
            begin
                if (iss_reg != cnt_reg)
                begin
                    mem_re      = 1'b1;
                    mem_raddr   = iss_reg[IW-1:0];
                    iss_next    = iss_reg + CW'(1);
                    rd_vld_next = 1'b1;
                    rd_pos_next = iss_reg;
                end
                if (rd_vld_reg)
                begin
                    if (op_reg == REQ_PICK && rd_pos_reg == '0)
                    begin
                        key_cur   = rd_data_reg.prio;
                        head_next = rd_data_reg;
                        key_next  = rd_data_reg.prio;
                    end
                    if (!found_reg && rd_data_reg.task_id == id_reg)
                    begin
                        found_next     = 1'b1;
                        found_pos_next = rd_pos_reg;
                    end
                    if (!ins_found_reg && rd_data_reg.prio > key_cur)
                    begin
                        ins_found_next = 1'b1;
                        ins_pos_next   = rd_pos_reg;
                    end
                    if (rd_pos_reg == cnt_reg - CW'(1))
                    begin
                        state_next = S_DECIDE;
                    end
                end
                if (cnt_reg == '0)
                begin
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                rsp_next           = '0;
                rsp_next.occupancy = OCC_W'(cnt_reg);
                mv_iss_next        = 1'b1;
                case (op_reg)
                    REQ_ENQUEUE:
                    begin
                        fin_pos_next = ins_pos_c;
                        up_next      = 1'b1;
                        src_next     = cnt_reg - CW'(1);
                        end_next     = ins_pos_c;
                        if (found_reg)
                        begin
                            rsp_next.status = STATUS_DUPLICATE;
                            done_next       = 1'b1;
                            state_next      = S_IDLE;
                        end
                        else if (cnt_reg == CW'(QUEUE_DEPTH))
                        begin
                            rsp_next.status = STATUS_FULL;
                            done_next       = 1'b1;
                            state_next      = S_IDLE;
                        end
                        else if (ins_pos_c != cnt_reg)
                        begin
                            state_next = S_MOVE;
                        end
                        else
                        begin
                            state_next = S_FINAL;
                        end
                    end
                    REQ_REMOVE:
                    begin
                        up_next  = 1'b0;
                        src_next = found_pos_reg + CW'(1);
                        end_next = cnt_reg - CW'(1);
                        if (!found_reg)
                        begin
                            rsp_next.status = STATUS_NOT_FOUND;
                            done_next       = 1'b1;
                            state_next      = S_IDLE;
                        end
                        else if (found_pos_reg != cnt_reg - CW'(1))
                        begin
                            state_next = S_MOVE;
                        end
                        else
                        begin
                            state_next = S_FINAL;
                        end
                    end
                    REQ_PICK:
                    begin
                        fin_pos_next = ins_pos_c - CW'(1);
                        up_next      = 1'b0;
                        src_next     = CW'(1);
                        end_next     = ins_pos_c - CW'(1);
                        if (cnt_reg == '0)
                        begin
                            rsp_next.picked_id = idle_id_reg;
                            rsp_next.is_idle   = 1'b1;
                            done_next          = 1'b1;
                            state_next         = S_IDLE;
                        end
                        else if (ins_pos_c >= CW'(2))
                        begin
                            state_next = S_MOVE;
                        end
                        else
                        begin
                            state_next = S_FINAL;
                        end
                    end
                    default:
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_MOVE:
            begin
                if (mv_iss_reg)
                begin
                    mem_re      = 1'b1;
                    mem_raddr   = src_reg[IW-1:0];
                    mv_vld_next = 1'b1;
                    dst_next    = up_reg ? src_reg + CW'(1) : src_reg - CW'(1);
                    if (src_reg == end_reg)
                    begin
                        mv_iss_next = 1'b0;
                    end
                    else
                    begin
                        src_next = up_reg ? src_reg - CW'(1) : src_reg + CW'(1);
                    end
                end
                if (mv_vld_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = dst_reg[IW-1:0];
                    mem_wdata = rd_data_reg;
                    if (!mv_iss_reg)
                    begin
                        state_next = S_FINAL;
                    end
                end
            end

            S_FINAL:
            begin
                rsp_next = '0;
                case (op_reg)
                    REQ_ENQUEUE:
                    begin
                        mem_we            = 1'b1;
                        mem_waddr         = fin_pos_reg[IW-1:0];
                        mem_wdata.task_id = id_reg;
                        mem_wdata.prio    = key_reg;
                        cnt_new           = cnt_reg + CW'(1);
                    end
                    REQ_REMOVE:
                    begin
                        cnt_new = cnt_reg - CW'(1);
                    end
                    REQ_PICK:
                    begin
                        mem_we                   = 1'b1;
                        mem_waddr                = fin_pos_reg[IW-1:0];
                        mem_wdata                = head_reg;
                        rsp_next.picked_id       = head_reg.task_id;
                        rsp_next.picked_priority = head_reg.prio;
                    end
                    default:
                    begin
                        cnt_new = cnt_reg;
                    end
                endcase
                cnt_next           = cnt_new;
                rsp_next.occupancy = OCC_W'(cnt_new);
                done_next          = 1'b1;
                state_next         = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            idle_id_reg   <= '1;
            op_reg        <= '0;
            id_reg        <= '0;
            key_reg       <= '0;
            head_reg      <= '0;
            iss_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            rd_pos_reg    <= '0;
            found_reg     <= 1'b0;
            found_pos_reg <= '0;
            ins_found_reg <= 1'b0;
            ins_pos_reg   <= '0;
            src_reg       <= '0;
            end_reg       <= '0;
            up_reg        <= 1'b0;
            mv_iss_reg    <= 1'b0;
            mv_vld_reg    <= 1'b0;
            dst_reg       <= '0;
            fin_pos_reg   <= '0;
            done_reg      <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            idle_id_reg   <= idle_id_next;
            op_reg        <= op_next;
            id_reg        <= id_next;
            key_reg       <= key_next;
            head_reg      <= head_next;
            iss_reg       <= iss_next;
            rd_vld_reg    <= rd_vld_next;
            rd_pos_reg    <= rd_pos_next;
            found_reg     <= found_next;
            found_pos_reg <= found_pos_next;
            ins_found_reg <= ins_found_next;
            ins_pos_reg   <= ins_pos_next;
            src_reg       <= src_next;
            end_reg       <= end_next;
            up_reg        <= up_next;
            mv_iss_reg    <= mv_iss_next;
            mv_vld_reg    <= mv_vld_next;
            dst_reg       <= dst_next;
            fin_pos_reg   <= fin_pos_next;
            done_reg      <= done_next;
            rsp_reg       <= rsp_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule
